@@ rtl/ssr_pkg.sv @@
// ----------------------------------------------------------------------------
// ssr_pkg: shared types, constants and reply tables
// Bus codes, register addresses, SD command indexes and the fixed reply
// byte tables used by the SPI-mode SD responder.
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

	// Default ring size
	localparam int RING_DEPTH_DEF = 128;

	// Bus operation codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// Register map (bit 0 of the address is ignored)
	localparam logic [15:0] ADDR_MASK = 16'hFFFE;
	localparam logic [15:0] ADDR_DATA = 16'h0020;
	localparam logic [15:0] ADDR_STAT = 16'h0022;

	// SD framing
	localparam logic [7:0] MISO_IDLE = 8'hFF;
	localparam int         START_BIT = 6;
	localparam logic [2:0] CMD_LEN   = 3'd6;

	// SD command indexes
	localparam logic [5:0] IDX_GO_IDLE  = 6'd0;
	localparam logic [5:0] IDX_SEND_IF  = 6'd8;
	localparam logic [5:0] IDX_APP_OP   = 6'd41;
	localparam logic [5:0] IDX_APP_CMD  = 6'd55;
	localparam logic [5:0] IDX_READ_OCR = 6'd58;

	// Ring operation issued by the sequencer
	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} ring_op_t;

	// Number of reply bytes for a command
	function automatic logic [2:0] reply_len(input logic [5:0] idx);
		logic [2:0] n;
		n = 3'd1;
		if (idx == IDX_SEND_IF || idx == IDX_READ_OCR)
			n = 3'd5;
		return n;
	endfunction

	// Reply byte k of a command
	function automatic logic [7:0] reply_byte(input logic [5:0] idx, input logic [2:0] k,
		input logic prefix);
		logic [7:0] b;
		b = 8'h04;
		unique case (idx)
			IDX_GO_IDLE:  b = 8'h01;
			IDX_APP_CMD:  b = 8'h01;
			IDX_APP_OP:   b = prefix ? 8'h00 : 8'h01;
			IDX_SEND_IF: begin
				unique case (k)
					3'd0:    b = 8'h01;
					3'd3:    b = 8'h01;
					3'd4:    b = 8'hAA;
					default: b = 8'h00;
				endcase
			end
			IDX_READ_OCR: begin
				b = (k == 3'd1) ? 8'hC0 : 8'h00;
			end
			default:      b = 8'h04;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

@@ rtl/ssr_ram.sv @@
// ----------------------------------------------------------------------------
// ssr_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/ssr_ring.sv @@
// ----------------------------------------------------------------------------
// ssr_ring: reply byte ring
// Head/tail pointers over a RAM. A push onto a full ring drops the oldest
// byte; a pop on an empty ring issues no read.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_ring #(
	parameter int RING_DEPTH = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ssr_pkg::ring_op_t op,
	input  wire logic [7:0]        push_data,
	output logic                   empty,
	output logic [7:0]             pop_data,
	output logic                   overfull
);
	import ssr_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] head_nx;
	logic [PTR_W-1:0] tail_nx;

	// Pointer advance with wrap at the ring end
	assign head_nx = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;

	assign empty    = (head_q == tail_q);
	assign overfull = (head_q > PTR_LAST) || (tail_q > PTR_LAST);

	// Pointer update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			priority if (op.clear) begin
				head_q <= '0;
				tail_q <= '0;
			end else if (op.push) begin
				if (tail_nx == head_q)
					head_q <= head_nx;
				tail_q <= tail_nx;
			end else if (op.pop) begin
				if (!empty)
					head_q <= head_nx;
			end
		end
	end

	ssr_ram #(
		.WIDTH (8),
		.DEPTH (RING_DEPTH),
		.ADDR_W(PTR_W)
	) u_ram (
		.clk  (clk),
		.we   (op.push && !op.clear),
		.waddr(tail_q),
		.wdata(push_data),
		.re   (op.pop && !op.clear && !empty),
		.raddr(head_q),
		.rdata(pop_data)
	);

endmodule

`default_nettype wire

@@ rtl/spi_sd_card_responder.sv @@
// ----------------------------------------------------------------------------
// spi_sd_card_responder: SPI controller with SD-card responder
// Bus-driven SPI port with an SD card in SPI mode behind it.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on rdata with done high for exactly one cycle and cannot be held
// off. Ticks, reads, control writes, select-high data writes and unknown
// operations return their result in the cycle after acceptance and leave
// busy low. A data write with select low goes through ST_POP and then
// ST_POP_WAIT before its result (one pop read from the reply RAM with
// registered data); a write that completes a 6-byte command first pushes
// its reply through the single RAM write port in ST_PUSH, one byte a
// cycle: five bytes for CMD8 and CMD58, one byte for other commands.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_sd_card_responder #(
	parameter int RING_DEPTH = ssr_pkg::RING_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] addr,
	input  wire logic [15:0] wdata,
	output logic             done,
	output logic [15:0]      rdata
);
	import ssr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_POP,
		ST_POP_WAIT
	} state_t;

	state_t      state_q;
	logic        sel_q;
	logic        ready_q;
	logic        pending_q;
	logic [7:0]  miso_q;
	logic [2:0]  count_q;
	logic        prefix_q;
	logic [2:0]  k_q;
	logic        hit_q;
	logic        done_q;
	logic [15:0] rdata_q;
	logic [7:0]  first_q;

	logic        accept;
	logic [15:0] addr_w;
	logic        is_data;
	logic        is_stat;
	logic [2:0]  count_inc;
	logic [5:0]  idx;
	logic        push_last;
	ring_op_t    ring_op;
	logic        ring_empty;
	logic [7:0]  ring_rdata;
	logic        ring_overfull;

	// Input decode
	assign accept    = start && (state_q == ST_IDLE);
	assign addr_w    = addr & ADDR_MASK;
	assign is_data   = (addr_w == ADDR_DATA);
	assign is_stat   = (addr_w == ADDR_STAT);
	assign count_inc = count_q + 3'd1;
	assign idx       = first_q[5:0];
	assign push_last = (k_q == reply_len(idx) - 3'd1);

	// Ring operations from the sequencer
	always_comb begin
		ring_op.clear = accept && (cmd == CMD_WRITE) && is_stat && wdata[1];
		ring_op.push  = (state_q == ST_PUSH);
		ring_op.pop   = (state_q == ST_POP);
	end

	ssr_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (ring_op),
		.push_data(reply_byte(idx, k_q, prefix_q)),
		.empty    (ring_empty),
		.pop_data (ring_rdata),
		.overfull (ring_overfull)
	);

	// Command first byte, kept only from the start of a command
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_WRITE && is_data && !sel_q && count_q == 3'd0 &&
			wdata[START_BIT])
			first_q <= wdata[7:0];
	end

	// Sequencer and responder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sel_q     <= 1'b1;
			ready_q   <= 1'b1;
			pending_q <= 1'b0;
			miso_q    <= MISO_IDLE;
			count_q   <= '0;
			prefix_q  <= 1'b0;
			k_q       <= '0;
			hit_q     <= 1'b0;
			done_q    <= 1'b0;
			rdata_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						rdata_q <= '0;
						done_q  <= 1'b1;
						unique case (cmd)
							CMD_TICK: begin
								if (pending_q) begin
									pending_q <= 1'b0;
									ready_q   <= 1'b1;
								end
							end
							CMD_READ: begin
								if (is_data)
									rdata_q <= {8'h00, miso_q};
								else if (is_stat)
									rdata_q <= {14'h0000, sel_q, ready_q};
							end
							CMD_WRITE: begin
								if (is_data) begin
									if (sel_q) begin
										miso_q    <= MISO_IDLE;
										ready_q   <= 1'b0;
										pending_q <= 1'b1;
										count_q   <= '0;
									end else begin
										// Result comes after the ring work
										done_q <= 1'b0;
										priority if (count_q == 3'd0) begin
											if (wdata[START_BIT])
												count_q <= 3'd1;
											state_q <= ST_POP;
										end else if (count_inc >= CMD_LEN) begin
											count_q <= '0;
											k_q     <= '0;
											state_q <= ST_PUSH;
										end else begin
											count_q <= count_inc;
											state_q <= ST_POP;
										end
									end
								end else if (is_stat) begin
									sel_q <= wdata[1];
									if (wdata[1]) begin
										count_q  <= '0;
										prefix_q <= 1'b0;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				// One reply byte a cycle into the ring
				ST_PUSH: begin
					k_q <= k_q + 3'd1;
					if (push_last) begin
						prefix_q <= (idx == IDX_APP_CMD);
						state_q  <= ST_POP;
					end
				end
				// Issue the pop read
				ST_POP: begin
					hit_q   <= !ring_empty;
					state_q <= ST_POP_WAIT;
				end
				// Take the popped byte and finish the transfer
				ST_POP_WAIT: begin
					miso_q    <= hit_q ? ring_rdata : MISO_IDLE;
					ready_q   <= 1'b0;
					pending_q <= 1'b1;
					rdata_q   <= '0;
					done_q    <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy  = (state_q != ST_IDLE);
	assign done  = done_q;
	assign rdata = rdata_q;

`ifndef SYNTHESIS
	// A finished ring transfer always yields its result next cycle
	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP_WAIT |=> done_q)
		else $error("pop result not delivered");

	// Every result follows an accepted item or a finished ring transfer
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(accept) || $past(state_q == ST_POP_WAIT)))
		else $error("result without an item");

	// Select cannot rise while a command reply is being pushed
	a_push_sel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUSH |-> !sel_q)
		else $error("reply push with select high");

	// Ring pointers stay inside the ring
	a_ring_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		!ring_overfull)
		else $error("ring pointer out of range");
`endif

endmodule

`default_nettype wire
